>>> hw/rtl/spmq_pkg.sv
`default_nettype none

package spmq_pkg;

   // fixed field widths
   localparam int PRIO_W   = 4;
   localparam int ID_W     = 4;
   localparam int DATA_W   = 32;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 6;

   // request operation codes
   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH  = 2'd0,
      KIND_POP   = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // one held message
   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [ID_W-1:0]   src;
      logic [ID_W-1:0]   dst;
      logic [ID_W-1:0]   msg_kind;
      logic [DATA_W-1:0] length;
      logic [DATA_W-1:0] handle;
   } entry_type;

   // command broadcast to every cell
   typedef struct packed {
      logic      push;
      logic      pop;
      logic      mode;
      entry_type entry;
   } cmd_type;

endpackage

`default_nettype wire

>>> hw/rtl/spmq_cell.sv
`default_nettype none

module spmq_cell (
   input  wire logic               clock,
   input  wire spmq_pkg::cmd_type   cmd,
   input  wire logic               occ,
   input  wire logic               after_in,
   input  wire logic               prev_after,
   input  wire spmq_pkg::entry_type left_entry,
   input  wire spmq_pkg::entry_type right_entry,
   output logic                    after_out,
   output spmq_pkg::entry_type      entry_out
);

   spmq_pkg::entry_type entry_ff;
   spmq_pkg::entry_type entry_in;
   logic                ge;

   // an entry the new message must stay behind
   assign ge        = occ && (!cmd.mode || (entry_ff.prio >= cmd.entry.prio));
   assign after_out = ge | after_in;
   assign entry_out = entry_ff;

   // insert here, shift right, or take from the right neighbor on pop
   always_comb begin
      entry_in = entry_ff;
      if (cmd.push) begin
         if (prev_after && !after_out) begin
            entry_in = cmd.entry;
         end else if (!prev_after) begin
            entry_in = left_entry;
         end
      end else if (cmd.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

>>> hw/rtl/stable_priority_message_queue_top.sv
`default_nettype none

// channel  direction  transfer when          payload
// req      in         req_valid & req_ready  kind, prio, src/dst id, msg_kind, length, handle
// rsp      out        rsp_valid & rsp_ready  status, popped message, occupancy
// csr      in         csr_wr_en              priority_mode
//
// one request per cycle while req_ready is high; its response is registered and shows the next cycle
// the row of DEPTH cells shifts or inserts in the same cycle a request transfers
// req_ready is low only while a response waits and rsp_ready is low
// synchronous reset empties the queue, sets priority mode, drops any response
// held message contents are not reset

module stable_priority_message_queue_top #(
   parameter int DEPTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [spmq_pkg::KIND_W-1:0]   req_kind,
   input  wire logic [spmq_pkg::PRIO_W-1:0]   req_prio,
   input  wire logic [spmq_pkg::ID_W-1:0]     req_src_id,
   input  wire logic [spmq_pkg::ID_W-1:0]     req_dst_id,
   input  wire logic [spmq_pkg::ID_W-1:0]     req_msg_kind,
   input  wire logic [spmq_pkg::DATA_W-1:0]   req_length,
   input  wire logic [spmq_pkg::DATA_W-1:0]   req_handle,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [spmq_pkg::STATUS_W-1:0]      rsp_status,
   output logic                               rsp_out_valid,
   output logic [spmq_pkg::PRIO_W-1:0]        rsp_out_prio,
   output logic [spmq_pkg::ID_W-1:0]          rsp_out_src,
   output logic [spmq_pkg::ID_W-1:0]          rsp_out_dst,
   output logic [spmq_pkg::ID_W-1:0]          rsp_out_msg_kind,
   output logic [spmq_pkg::DATA_W-1:0]        rsp_out_length,
   output logic [spmq_pkg::DATA_W-1:0]        rsp_out_handle,
   output logic [spmq_pkg::OCC_W-1:0]         rsp_occupancy,
   input  wire logic                          csr_wr_en,
   input  wire logic                          csr_wr_data
);

   localparam int CW = $clog2(DEPTH + 1);

   logic                 mode_ff;
   logic [CW-1:0]        fill_ff;
   logic [CW-1:0]        fill_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   spmq_pkg::status_type rsp_status_ff;
   spmq_pkg::status_type rsp_status_in;
   logic                 rsp_out_valid_ff;
   logic                 rsp_out_valid_in;
   spmq_pkg::entry_type  rsp_entry_ff;
   spmq_pkg::entry_type  rsp_entry_in;
   logic [spmq_pkg::OCC_W-1:0] rsp_occ_ff;
   logic [spmq_pkg::OCC_W-1:0] rsp_occ_in;
   logic [CW+spmq_pkg::OCC_W-1:0] occ_wide;

   logic                 req_fire;
   logic                 full;
   logic                 empty;
   spmq_pkg::kind_type   kind;
   spmq_pkg::cmd_type    cmd;

   logic                 after_w [DEPTH+1];
   logic                 occ_w   [DEPTH];
   spmq_pkg::entry_type  ent_w   [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign kind      = spmq_pkg::kind_type'(req_kind);
   assign full      = (fill_ff == CW'(DEPTH));
   assign empty     = (fill_ff == '0);

   // command to the cell row
   always_comb begin
      cmd.push           = req_fire && (kind == spmq_pkg::KIND_PUSH) && !full;
      cmd.pop            = req_fire && (kind == spmq_pkg::KIND_POP) && !empty;
      cmd.mode           = mode_ff;
      cmd.entry.prio     = req_prio;
      cmd.entry.src      = req_src_id;
      cmd.entry.dst      = req_dst_id;
      cmd.entry.msg_kind = req_msg_kind;
      cmd.entry.length   = req_length;
      cmd.entry.handle   = req_handle;
   end

   // cell row, head at cell 0
   assign after_w[DEPTH] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spmq_pkg::entry_type left_e;
      spmq_pkg::entry_type right_e;
      logic                prev_a;

      assign occ_w[i] = (CW'(i) < fill_ff);

      if (i == 0) begin : g_head
         assign prev_a = 1'b1;
         assign left_e = cmd.entry;
      end else begin : g_body
         assign prev_a = after_w[i-1];
         assign left_e = ent_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_e = ent_w[i];
      end else begin : g_inner
         assign right_e = ent_w[i+1];
      end

      spmq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occ         (occ_w[i]),
         .after_in    (after_w[i+1]),
         .prev_after  (prev_a),
         .left_entry  (left_e),
         .right_entry (right_e),
         .after_out   (after_w[i]),
         .entry_out   (ent_w[i])
      );
   end

   // fill count and response
   always_comb begin
      fill_in          = fill_ff;
      rsp_status_in    = spmq_pkg::STATUS_DONE;
      rsp_out_valid_in = 1'b0;
      rsp_entry_in     = '0;
      case (kind)
         spmq_pkg::KIND_PUSH: begin
            if (full) begin
               rsp_status_in = spmq_pkg::STATUS_FULL;
            end else begin
               fill_in = fill_ff + 1'b1;
            end
         end
         spmq_pkg::KIND_POP: begin
            if (empty) begin
               rsp_status_in = spmq_pkg::STATUS_EMPTY;
            end else begin
               fill_in          = fill_ff - 1'b1;
               rsp_out_valid_in = 1'b1;
               rsp_entry_in     = ent_w[0];
            end
         end
         spmq_pkg::KIND_CLEAR: begin
            fill_in = '0;
         end
         default: begin
            fill_in = fill_ff;
         end
      endcase
      occ_wide   = {{spmq_pkg::OCC_W{1'b0}}, fill_in};
      rsp_occ_in = occ_wide[spmq_pkg::OCC_W-1:0];
   end

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b1;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (req_fire) begin
            fill_ff <= fill_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_status_ff    <= rsp_status_in;
         rsp_out_valid_ff <= rsp_out_valid_in;
         rsp_entry_ff     <= rsp_entry_in;
         rsp_occ_ff       <= rsp_occ_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_valid    = rsp_out_valid_ff;
   assign rsp_out_prio     = rsp_entry_ff.prio;
   assign rsp_out_src      = rsp_entry_ff.src;
   assign rsp_out_dst      = rsp_entry_ff.dst;
   assign rsp_out_msg_kind = rsp_entry_ff.msg_kind;
   assign rsp_out_length   = rsp_entry_ff.length;
   assign rsp_out_handle   = rsp_entry_ff.handle;
   assign rsp_occupancy    = rsp_occ_ff;

   // fill count stays within the row
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill count beyond depth");

   // fill count moves only on a request transfer
   a_fill_hold: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(fill_ff))
      else $error("fill count changed without a transfer");

   // clear reports an empty queue
   a_clear_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && kind == spmq_pkg::KIND_CLEAR) |=>
         (rsp_occ_ff == '0 && rsp_status_ff == spmq_pkg::STATUS_DONE))
      else $error("clear response wrong");

   // a popped message always comes with done status
   a_pop_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_out_valid_ff) |-> rsp_status_ff == spmq_pkg::STATUS_DONE)
      else $error("popped message with error status");

   // a response waiting on a stall blocks new requests
   a_stall_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken over a held response");

endmodule

`default_nettype wire

>>> bench/spmq_order_monitor.sv
`timescale 1ns / 1ps

// watches the request, response and csr ports, keeps its own copy of the
// queue, and compares every response transfer with the oldest prediction
module spmq_order_monitor
   import spmq_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_ready,
   input  wire logic [KIND_W-1:0]   req_kind,
   input  wire logic [PRIO_W-1:0]   req_prio,
   input  wire logic [ID_W-1:0]     req_src_id,
   input  wire logic [ID_W-1:0]     req_dst_id,
   input  wire logic [ID_W-1:0]     req_msg_kind,
   input  wire logic [DATA_W-1:0]   req_length,
   input  wire logic [DATA_W-1:0]   req_handle,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_ready,
   input  wire logic [STATUS_W-1:0] rsp_status,
   input  wire logic                rsp_out_valid,
   input  wire logic [PRIO_W-1:0]   rsp_out_prio,
   input  wire logic [ID_W-1:0]     rsp_out_src,
   input  wire logic [ID_W-1:0]     rsp_out_dst,
   input  wire logic [ID_W-1:0]     rsp_out_msg_kind,
   input  wire logic [DATA_W-1:0]   rsp_out_length,
   input  wire logic [DATA_W-1:0]   rsp_out_handle,
   input  wire logic [OCC_W-1:0]    rsp_occupancy,
   input  wire logic                csr_wr_en,
   input  wire logic                csr_wr_data,
   output int                       fail_count,
   output int                       pending
);

   // one predicted response
   typedef struct packed {
      status_type       status;
      logic             out_valid;
      entry_type        msg;
      logic [OCC_W-1:0] occupancy;
   } queue_reply_type;

   entry_type       held [DEPTH];
   int              held_count;
   logic            prio_order;
   queue_reply_type due_replies [$];
   int              mismatches;
   int              replies_seen;

   initial begin
      fail_count <= 0;
      pending    <= 0;
      mismatches = 0;
      replies_seen = 0;
      held_count = 0;
      prio_order = 1'b1;
   end

   // apply one request to the shadow queue and return its response
   function automatic queue_reply_type apply_queue_op(input logic [KIND_W-1:0] kind,
                                                      input entry_type msg);
      queue_reply_type r;
      int              at;
      r = '0;
      case (kind)
         KIND_PUSH: begin
            if (held_count >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               at = held_count;
               // stable insert: pass only entries of strictly lower priority
               if (prio_order) begin
                  while (at > 0 && held[at-1].prio < msg.prio) begin
                     held[at] = held[at-1];
                     at--;
                  end
               end
               held[at] = msg;
               held_count++;
            end
         end
         KIND_POP: begin
            if (held_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.out_valid = 1'b1;
               r.msg       = held[0];
               for (int i = 1; i < held_count; i++) held[i-1] = held[i];
               held_count--;
            end
         end
         KIND_CLEAR: begin
            held_count = 0;
         end
         default: ;
      endcase
      r.occupancy = OCC_W'(held_count);
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] response %0d: %s", $realtime, replies_seen, what);
      mismatches++;
   endtask

   // field by field compare of the response on the ports
   task automatic compare_reply(input queue_reply_type want);
      if (rsp_status !== want.status)
         report_mismatch($sformatf("status %0h, expected %0h", rsp_status, want.status));
      if (rsp_out_valid !== want.out_valid)
         report_mismatch($sformatf("out_valid %0h, expected %0h", rsp_out_valid,
                                   want.out_valid));
      if (rsp_out_prio !== want.msg.prio)
         report_mismatch($sformatf("out_prio %0h, expected %0h", rsp_out_prio,
                                   want.msg.prio));
      if (rsp_out_src !== want.msg.src)
         report_mismatch($sformatf("out_src %0h, expected %0h", rsp_out_src, want.msg.src));
      if (rsp_out_dst !== want.msg.dst)
         report_mismatch($sformatf("out_dst %0h, expected %0h", rsp_out_dst, want.msg.dst));
      if (rsp_out_msg_kind !== want.msg.msg_kind)
         report_mismatch($sformatf("out_msg_kind %0h, expected %0h", rsp_out_msg_kind,
                                   want.msg.msg_kind));
      if (rsp_out_length !== want.msg.length)
         report_mismatch($sformatf("out_length %0h, expected %0h", rsp_out_length,
                                   want.msg.length));
      if (rsp_out_handle !== want.msg.handle)
         report_mismatch($sformatf("out_handle %0h, expected %0h", rsp_out_handle,
                                   want.msg.handle));
      if (rsp_occupancy !== want.occupancy)
         report_mismatch($sformatf("occupancy %0d, expected %0d", rsp_occupancy,
                                   want.occupancy));
   endtask

   // sample every transfer at the clock edge
   always @(posedge clock) begin
      entry_type incoming;
      if (reset) begin
         held_count = 0;
         prio_order = 1'b1;
         due_replies.delete();
      end else begin
         // response transfer
         if (rsp_valid && rsp_ready) begin
            if (due_replies.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               compare_reply(due_replies.pop_front());
            end
            replies_seen++;
         end

         // request transfer sees the mode held before this edge
         if (req_valid && req_ready) begin
            incoming.prio     = req_prio;
            incoming.src      = req_src_id;
            incoming.dst      = req_dst_id;
            incoming.msg_kind = req_msg_kind;
            incoming.length   = req_length;
            incoming.handle   = req_handle;
            due_replies.push_back(apply_queue_op(req_kind, incoming));
         end

         if (csr_wr_en) prio_order = csr_wr_data;
      end
      pending    <= due_replies.size();
      fail_count <= mismatches;
   end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import spmq_pkg::*;

   localparam int DEPTH      = 32;
   localparam int STALL_LIMIT = 2000;

   logic                clock;
   logic                reset        = 1'b1;
   logic                req_valid    = 1'b0;
   logic                req_ready;
   logic [KIND_W-1:0]   req_kind     = '0;
   logic [PRIO_W-1:0]   req_prio     = '0;
   logic [ID_W-1:0]     req_src_id   = '0;
   logic [ID_W-1:0]     req_dst_id   = '0;
   logic [ID_W-1:0]     req_msg_kind = '0;
   logic [DATA_W-1:0]   req_length   = '0;
   logic [DATA_W-1:0]   req_handle   = '0;
   logic                rsp_valid;
   logic                rsp_ready    = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_out_valid;
   logic [PRIO_W-1:0]   rsp_out_prio;
   logic [ID_W-1:0]     rsp_out_src;
   logic [ID_W-1:0]     rsp_out_dst;
   logic [ID_W-1:0]     rsp_out_msg_kind;
   logic [DATA_W-1:0]   rsp_out_length;
   logic [DATA_W-1:0]   rsp_out_handle;
   logic [OCC_W-1:0]    rsp_occupancy;
   logic                csr_wr_en    = 1'b0;
   logic                csr_wr_data  = 1'b0;

   int fail_count;
   int pending;
   int idle_pct  = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;

   stable_priority_message_queue_top #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_prio        (req_prio),
      .req_src_id      (req_src_id),
      .req_dst_id      (req_dst_id),
      .req_msg_kind    (req_msg_kind),
      .req_length      (req_length),
      .req_handle      (req_handle),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_out_valid   (rsp_out_valid),
      .rsp_out_prio    (rsp_out_prio),
      .rsp_out_src     (rsp_out_src),
      .rsp_out_dst     (rsp_out_dst),
      .rsp_out_msg_kind(rsp_out_msg_kind),
      .rsp_out_length  (rsp_out_length),
      .rsp_out_handle  (rsp_out_handle),
      .rsp_occupancy   (rsp_occupancy),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   spmq_order_monitor #(
      .DEPTH(DEPTH)
   ) i_order_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_prio        (req_prio),
      .req_src_id      (req_src_id),
      .req_dst_id      (req_dst_id),
      .req_msg_kind    (req_msg_kind),
      .req_length      (req_length),
      .req_handle      (req_handle),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_out_valid   (rsp_out_valid),
      .rsp_out_prio    (rsp_out_prio),
      .rsp_out_src     (rsp_out_src),
      .rsp_out_dst     (rsp_out_dst),
      .rsp_out_msg_kind(rsp_out_msg_kind),
      .rsp_out_length  (rsp_out_length),
      .rsp_out_handle  (rsp_out_handle),
      .rsp_occupancy   (rsp_occupancy),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   // 50 MHz clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // response side back-pressure
   initial begin
      forever begin
         @(posedge clock);
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // one request transfer, with random idle cycles ahead of it
   task automatic send_request(input kind_type kind, input logic [PRIO_W-1:0] prio,
                               input logic [ID_W-1:0] src, input logic [ID_W-1:0] dst,
                               input logic [ID_W-1:0] mkind, input logic [DATA_W-1:0] len,
                               input logic [DATA_W-1:0] hnd);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_prio     <= prio;
      req_src_id   <= src;
      req_dst_id   <= dst;
      req_msg_kind <= mkind;
      req_length   <= len;
      req_handle   <= hnd;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // wait for every response, then change the priority mode
   task automatic drain_and_set_mode(input logic prio_on);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= prio_on;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // random traffic in stretches that fill, churn or drain the queue
   task automatic run_traffic(input int count);
      int push_pct;
      int pick;
      logic [PRIO_W-1:0] prio;
      push_pct = 50;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(2))
               0:       push_pct = 85;
               1:       push_pct = 50;
               default: push_pct = 15;
            endcase
         end
         pick = $urandom_range(99);
         // bias some priorities onto a narrow band so ties are common
         prio = ($urandom_range(3) == 0) ? PRIO_W'(6 + $urandom_range(1))
                                         : PRIO_W'($urandom_range(15));
         if (pick < 2)
            send_request(KIND_CLEAR, PRIO_W'($urandom), ID_W'($urandom), ID_W'($urandom),
                         ID_W'($urandom), $urandom, $urandom);
         else if (pick < 2 + push_pct)
            send_request(KIND_PUSH, prio, ID_W'($urandom), ID_W'($urandom),
                         ID_W'($urandom), pick_word(), pick_word());
         else
            send_request(KIND_POP, PRIO_W'($urandom), ID_W'($urandom), ID_W'($urandom),
                         ID_W'($urandom), $urandom, $urandom);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pop, priority extremes, ties, drain, clear
      send_request(KIND_POP,   4'd0,  4'h0, 4'h0, 4'h0, 32'h0, 32'h0);
      send_request(KIND_PUSH,  4'd0,  4'h0, 4'h0, 4'h0, 32'h0, 32'h0);
      send_request(KIND_PUSH,  4'd15, 4'hf, 4'hf, 4'hf, 32'hffff_ffff, 32'hffff_ffff);
      send_request(KIND_PUSH,  4'd7,  4'h5, 4'ha, 4'h3, 32'h1, 32'h2);
      send_request(KIND_PUSH,  4'd7,  4'ha, 4'h5, 4'hc, 32'h3, 32'h4);
      send_request(KIND_PUSH,  4'd15, 4'h1, 4'h2, 4'h4, 32'h8000_0000, 32'h5555_aaaa);
      send_request(KIND_PUSH,  4'd0,  4'h8, 4'h9, 4'h6, 32'haaaa_5555, 32'h7fff_ffff);
      repeat (6) send_request(KIND_POP, 4'd0, 4'h0, 4'h0, 4'h0, 32'h0, 32'h0);
      send_request(KIND_POP,   4'd0,  4'h0, 4'h0, 4'h0, 32'h0, 32'h0);
      send_request(KIND_PUSH,  4'd3,  4'h3, 4'h3, 4'h3, 32'h33, 32'h33);
      send_request(KIND_PUSH,  4'd9,  4'h9, 4'h9, 4'h9, 32'h99, 32'h99);
      send_request(KIND_CLEAR, 4'd0,  4'h0, 4'h0, 4'h0, 32'h0, 32'h0);
      send_request(KIND_POP,   4'd0,  4'h0, 4'h0, 4'h0, 32'h0, 32'h0);

      // plain fifo, no idling
      drain_and_set_mode(1'b0);
      run_traffic(108);

      // priority order, sender idles
      idle_pct = 61;
      drain_and_set_mode(1'b1);
      run_traffic(108);

      // plain fifo, receiver stalls
      idle_pct  = 0;
      stall_pct = 61;
      drain_and_set_mode(1'b0);
      run_traffic(108);

      // priority order, both sides idle
      idle_pct  = 32;
      stall_pct = 32;
      drain_and_set_mode(1'b1);
      run_traffic(108);

      // let the last responses arrive
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (5) @(posedge clock);

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/spmq_pkg.sv
hw/rtl/spmq_cell.sv
hw/rtl/stable_priority_message_queue_top.sv
bench/spmq_order_monitor.sv
bench/tb_top.sv
